@@ src/tanc_pkg.sv @@
// ----------------------------------------------------------------------------
// tanc_pkg
// Widths, constants and pipeline beat types shared by the triangle
// area / normal / centroid datapath.
// ----------------------------------------------------------------------------
package tanc_pkg;

  // coordinate format
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int NVERT     = 3;
  localparam int NAXES     = 3;
  localparam int IN_W      = NVERT * NAXES * COORD_W;

  // edge vectors and cross product
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;

  // centroid: sum of three coordinates and divide by three
  localparam int SUM3_W      = COORD_W + 2;
  localparam int CMAG_W      = COORD_W + 1;
  localparam int CPROD_W     = 2 * CMAG_W;
  localparam int RECIP_SHIFT = CMAG_W + 1;
  localparam logic [CMAG_W-1:0] RECIP3 = CMAG_W'((64'd1 << RECIP_SHIFT) / 64'd3 + 64'd1);

  // normal division: quotient of sq * 2^(2*NORM_FRAC+2) over sum of squares
  localparam int NORM_FRAC = 30;
  localparam int QUO_W     = 2 * NORM_FRAC + 3;
  localparam int PREM_W    = SUM_W + 1;
  localparam int DIV_CELLS = QUO_W;

  // square root chain
  localparam int RAD_W      = SUM_W - 2 * FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int SQ_LANES   = NAXES + 1;

  // result format
  localparam int AREA_W = 64;
  localparam int NORM_W = 32;
  localparam int OUT_W  = AREA_W + NAXES * NORM_W + NAXES * COORD_W;

  // one lane of the restoring divider
  typedef struct packed {
    logic [PREM_W-1:0] p;
    logic              nb;
    logic [QUO_W-1:0]  q;
  } div_lane_t;

  // beat moving down the divider chain
  typedef struct packed {
    logic                            valid;
    logic                            tri_ok;
    logic [NAXES-1:0]                neg;
    logic [NAXES-1:0][COORD_W-1:0]   center;
    logic [RAD_W-1:0]                area_rad;
    logic [SUM_W-1:0]                d;
    div_lane_t [NAXES-1:0]           lane;
  } div_pipe_t;

  // one lane of the digit-by-digit square root
  typedef struct packed {
    logic [RAD_W-1:0]  x;
    logic [SREM_W-1:0] r;
    logic [ROOT_W-1:0] q;
  } sqrt_lane_t;

  // beat moving down the square root chain; lane 0 is the area
  typedef struct packed {
    logic                            valid;
    logic                            tri_ok;
    logic [NAXES-1:0]                neg;
    logic [NAXES-1:0][COORD_W-1:0]   center;
    sqrt_lane_t [SQ_LANES-1:0]       lane;
  } sqrt_pipe_t;

endpackage

@@ src/tanc_front.sv @@
// ----------------------------------------------------------------------------
// tanc_front
// Edge vectors, cross product, squared magnitudes and centroid; six
// register stages feeding the divider chain.
// ----------------------------------------------------------------------------
module tanc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tanc_pkg::IN_W-1:0]    in_data,
  output tanc_pkg::div_pipe_t          dout
);
  import tanc_pkg::*;

  localparam int NSTG = 5;

  logic                       vld [NSTG];
  logic signed [COORD_W-1:0]  v   [NVERT*NAXES];

  // stage 1
  logic [EDGE_W-1:0]          a_n [NAXES];
  logic [EDGE_W-1:0]          b_n [NAXES];
  logic [SUM3_W-1:0]          s3_n [NAXES];
  logic signed [EDGE_W-1:0]   a [NAXES];
  logic signed [EDGE_W-1:0]   b [NAXES];
  logic signed [SUM3_W-1:0]   s3 [NAXES];

  // stage 2
  logic signed [PROD_W-1:0]   pa [NAXES];
  logic signed [PROD_W-1:0]   pb [NAXES];
  logic [SUM3_W-1:0]          s3_mag [NAXES];
  logic [CMAG_W-1:0]          cmag [NAXES];
  logic [CMAG_W-1:0]          cprod_in [NAXES];
  logic [NAXES-1:0]           cneg2;

  // stage 3
  logic [CROSS_W-1:0]         cr [NAXES];
  logic [CROSS_W-1:0]         cr_neg [NAXES];
  logic [MAG_W-1:0]           cm [NAXES];
  logic [NAXES-1:0]           neg3;
  logic [CPROD_W-1:0]         cprod [NAXES];
  logic [NAXES-1:0]           cneg3;

  // stage 4
  logic [PROD_W-1:0]          hh [NAXES];
  logic [PROD_W-1:0]          hl [NAXES];
  logic [PROD_W-1:0]          ll [NAXES];
  logic [NAXES-1:0]           neg4;
  logic [COORD_W-1:0]         cq [NAXES];
  logic [COORD_W-1:0]         ctr4 [NAXES];

  // stage 5
  logic [SQ_W-1:0]            sq [NAXES];
  logic [NAXES-1:0]           neg5;
  logic [COORD_W-1:0]         ctr5 [NAXES];

  // stage 6
  logic [SUM_W-1:0]           ssum;
  div_pipe_t                  dout_next;

  // unpack the beat, first field lowest
  always_comb begin
    for (int k = 0; k < NVERT * NAXES; k++) begin
      v[k] = in_data[k*COORD_W +: COORD_W];
    end
  end

  // edges and coordinate sums
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      a_n[i] = {v[NAXES+i][COORD_W-1], v[NAXES+i]} - {v[i][COORD_W-1], v[i]};
      b_n[i] = {v[2*NAXES+i][COORD_W-1], v[2*NAXES+i]} - {v[i][COORD_W-1], v[i]};
      s3_n[i] = {{2{v[i][COORD_W-1]}}, v[i]}
              + {{2{v[NAXES+i][COORD_W-1]}}, v[NAXES+i]}
              + {{2{v[2*NAXES+i][COORD_W-1]}}, v[2*NAXES+i]};
    end
  end

  // centroid magnitude plus one for round to nearest
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      s3_mag[i] = s3[i][SUM3_W-1] ? (~s3[i] + 1'b1) : s3[i];
      cmag[i]   = s3_mag[i][CMAG_W-1:0] + 1'b1;
    end
  end

  // cross product sign and magnitude
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      cr[i]     = {pa[i][PROD_W-1], pa[i]} - {pb[i][PROD_W-1], pb[i]};
      cr_neg[i] = ~cr[i] + 1'b1;
    end
  end

  // quotient by three, then sign
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      cq[i] = cprod[i][RECIP_SHIFT +: COORD_W];
    end
  end

  // sum of squares and divider seed
  always_comb begin
    ssum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    dout_next.valid    = vld[NSTG-1];
    dout_next.tri_ok   = (ssum != '0);
    dout_next.neg      = neg5;
    dout_next.d        = ssum;
    dout_next.area_rad = ssum[SUM_W-1 -: RAD_W];
    for (int i = 0; i < NAXES; i++) begin
      dout_next.center[i]  = ctr5[i];
      dout_next.lane[i].p  = PREM_W'(sq[i][SQ_W-1:1]);
      dout_next.lane[i].nb = sq[i][0];
      dout_next.lane[i].q  = '0;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) vld[k] <= vld[k-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NAXES; i++) begin
        a[i]  <= a_n[i];
        b[i]  <= b_n[i];
        s3[i] <= s3_n[i];
      end
      pa[0] <= a[1] * b[2];
      pb[0] <= a[2] * b[1];
      pa[1] <= a[2] * b[0];
      pb[1] <= a[0] * b[2];
      pa[2] <= a[0] * b[1];
      pb[2] <= a[1] * b[0];
      for (int i = 0; i < NAXES; i++) begin
        cneg2[i] <= s3[i][SUM3_W-1];
        cprod_in[i] <= cmag[i];

        neg3[i]  <= cr[i][CROSS_W-1];
        cm[i]    <= cr[i][CROSS_W-1] ? cr_neg[i][MAG_W-1:0] : cr[i][MAG_W-1:0];
        cprod[i] <= CPROD_W'(cprod_in[i]) * CPROD_W'(RECIP3);
        cneg3[i] <= cneg2[i];

        hh[i]   <= PROD_W'(cm[i][MAG_W-1:HALF_W]) * PROD_W'(cm[i][MAG_W-1:HALF_W]);
        hl[i]   <= PROD_W'(cm[i][MAG_W-1:HALF_W]) * PROD_W'(cm[i][HALF_W-1:0]);
        ll[i]   <= PROD_W'(cm[i][HALF_W-1:0]) * PROD_W'(cm[i][HALF_W-1:0]);
        neg4[i] <= neg3[i];
        ctr4[i] <= cneg3[i] ? (~cq[i] + 1'b1) : cq[i];

        sq[i]   <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1))
                 + SQ_W'(ll[i]);
        neg5[i] <= neg4[i];
        ctr5[i] <= ctr4[i];
      end
    end
  end

  // beat handed to the divider chain
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout <= dout_next;
  end

endmodule

@@ src/tanc_div_cell.sv @@
// ----------------------------------------------------------------------------
// tanc_div_cell
// One restoring-division step on three lanes sharing one divisor; yields
// one quotient bit per lane and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module tanc_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  tanc_pkg::div_pipe_t  din,
  output tanc_pkg::div_pipe_t  dout
);
  import tanc_pkg::*;

  logic [PREM_W-1:0] t  [NAXES];
  logic              ge [NAXES];
  div_pipe_t         dout_next;

  // shift in one dividend bit, trial subtract
  always_comb begin
    dout_next = din;
    for (int k = 0; k < NAXES; k++) begin
      t[k]  = {din.lane[k].p[PREM_W-2:0], din.lane[k].nb};
      ge[k] = (t[k] >= {1'b0, din.d});
      dout_next.lane[k].p  = ge[k] ? (t[k] - {1'b0, din.d}) : t[k];
      dout_next.lane[k].q  = {din.lane[k].q[QUO_W-2:0], ge[k]};
      dout_next.lane[k].nb = 1'b0;
    end
  end

  // hand off to neighbor
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout <= dout_next;
  end

endmodule

@@ src/tanc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tanc_sqrt_cell
// One digit-by-digit integer square root step on four lanes; yields one
// root bit per lane and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module tanc_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tanc_pkg::sqrt_pipe_t  din,
  output tanc_pkg::sqrt_pipe_t  dout
);
  import tanc_pkg::*;

  logic [SREM_W-1:0] t     [SQ_LANES];
  logic [SREM_W-1:0] trial [SQ_LANES];
  logic              ge    [SQ_LANES];
  sqrt_pipe_t        dout_next;

  // bring down two radicand bits, trial subtract
  always_comb begin
    dout_next = din;
    for (int k = 0; k < SQ_LANES; k++) begin
      t[k]     = {din.lane[k].r[SREM_W-3:0], din.lane[k].x[RAD_W-1 -: 2]};
      trial[k] = {din.lane[k].q, 2'b01};
      ge[k]    = (t[k] >= trial[k]);
      dout_next.lane[k].r = ge[k] ? (t[k] - trial[k]) : t[k];
      dout_next.lane[k].q = {din.lane[k].q[ROOT_W-2:0], ge[k]};
      dout_next.lane[k].x = {din.lane[k].x[RAD_W-3:0], 2'b00};
    end
  end

  // hand off to neighbor
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout <= dout_next;
  end

endmodule

@@ src/triangle_area_normal_centroid.sv @@
// An input beat passes through 121 register stages on its way to the output.
// Throughput: one triangle per cycle while the skid entry is free, set by the
// 63-cell divider chain and the 51-cell square root chain, each cell passing
// its beat on every enabled cycle. An output register plus one skid entry
// keep input open while a result waits. Reset (rst, synchronous) clears
// every stage's valid bit.
// ----------------------------------------------------------------------------
// triangle_area_normal_centroid
// Streams triangles in and returns area, unit normal and centroid per beat.
// ----------------------------------------------------------------------------
module triangle_area_normal_centroid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z
  input  logic [tanc_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // area, normal_x, normal_y, normal_z, center_x, center_y, center_z
  output logic [tanc_pkg::OUT_W-1:0]    m_tdata,
  // tri_valid
  output logic [0:0]                    m_tuser
);
  import tanc_pkg::*;

  logic       en;
  div_pipe_t  dstg [DIV_CELLS+1];
  sqrt_pipe_t sstg [SQRT_CELLS+1];
  sqrt_pipe_t sqrt_seed;

  logic [ROOT_W:0]      rnd  [SQ_LANES];
  logic [ROOT_W-1:0]    half [SQ_LANES];
  logic [NORM_W-1:0]    nrm  [NAXES];
  logic [OUT_W-1:0]     res_data;
  logic                 skid_valid;
  logic [OUT_W-1:0]     skid_data;
  logic [0:0]           skid_user;

  // pipeline moves whenever the skid entry is free
  assign en       = ~skid_valid;
  assign s_tready = en & ~rst;

  tanc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .dout     (dstg[0])
  );

  // divider chain
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    tanc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dstg[g]),
      .dout (dstg[g+1])
    );
  end

  // square root seed: area radicand and three normal quotients
  always_comb begin
    sqrt_seed.valid  = dstg[DIV_CELLS].valid;
    sqrt_seed.tri_ok = dstg[DIV_CELLS].tri_ok;
    sqrt_seed.neg    = dstg[DIV_CELLS].neg;
    sqrt_seed.center = dstg[DIV_CELLS].center;
    sqrt_seed.lane[0].x = dstg[DIV_CELLS].area_rad;
    sqrt_seed.lane[0].r = '0;
    sqrt_seed.lane[0].q = '0;
    for (int k = 0; k < NAXES; k++) begin
      sqrt_seed.lane[k+1].x = RAD_W'(dstg[DIV_CELLS].lane[k].q);
      sqrt_seed.lane[k+1].r = '0;
      sqrt_seed.lane[k+1].q = '0;
    end
  end

  assign sstg[0] = sqrt_seed;

  // square root chain
  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    tanc_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sstg[g]),
      .dout (sstg[g+1])
    );
  end

  // round the roots, apply signs, zero degenerate results
  always_comb begin
    for (int k = 0; k < SQ_LANES; k++) begin
      rnd[k]  = {1'b0, sstg[SQRT_CELLS].lane[k].q} + 1'b1;
      half[k] = rnd[k][ROOT_W:1];
    end
    for (int k = 0; k < NAXES; k++) begin
      nrm[k] = sstg[SQRT_CELLS].neg[k] ? (~half[k+1][NORM_W-1:0] + 1'b1)
                                       : half[k+1][NORM_W-1:0];
      if (!sstg[SQRT_CELLS].tri_ok) nrm[k] = '0;
    end
    res_data = '0;
    if (sstg[SQRT_CELLS].tri_ok) res_data[AREA_W-1:0] = AREA_W'(half[0]);
    for (int k = 0; k < NAXES; k++) begin
      res_data[AREA_W + k*NORM_W +: NORM_W] = nrm[k];
      res_data[AREA_W + NAXES*NORM_W + k*COORD_W +: COORD_W] =
        sstg[SQRT_CELLS].center[k];
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= skid_data;
        m_tuser    <= skid_user;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= sstg[SQRT_CELLS].valid;
        m_tdata  <= res_data;
        m_tuser  <= sstg[SQRT_CELLS].tri_ok;
      end
    end else if (en && sstg[SQRT_CELLS].valid) begin
      skid_valid <= 1'b1;
      skid_data  <= res_data;
      skid_user  <= sstg[SQRT_CELLS].tri_ok;
    end
  end

endmodule

@@ tb/triangle_area_normal_centroid_checker.sv @@
// ----------------------------------------------------------------------------
// triangle_area_normal_centroid_checker
// Watches both stream channels, predicts area, unit normal and centroid for
// every accepted triangle and compares each output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_area_normal_centroid_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [tanc_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [tanc_pkg::OUT_W-1:0] m_tdata,
  input  logic [0:0]                 m_tuser,
  output int                         fails,
  output int                         waiting,
  output int                         checked,
  output int                         flat_seen
);
  import tanc_pkg::*;

  typedef struct {
    logic        ok;
    logic [63:0] area;
    logic [31:0] nrm [3];
    logic [31:0] ctr [3];
  } tri_result_t;

  tri_result_t result_q [$];

  // floor of the square root, bit by bit
  function automatic logic [255:0] root_floor(input logic [255:0] x);
    logic [255:0] r, rem, b, t;
    r = '0;
    rem = x;
    b = 256'd1 << 254;
    while (b != 0 && b > rem) b = b >> 2;
    while (b != 0) begin
      t = r + b;
      if (rem >= t) begin
        rem = rem - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // area, normal and centroid of one triangle
  function automatic tri_result_t triangle_props(input logic [IN_W-1:0] d);
    tri_result_t res;
    longint v [9];
    longint sum, q;
    logic signed [159:0] ea [3], eb [3], cr [3];
    logic [255:0] mg [3], ssq, t;
    logic neg [3];
    logic a_nz, b_nz;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(d[i*COORD_W +: COORD_W]));
    a_nz = 1'b0;
    b_nz = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = v[i] + v[3+i] + v[6+i];
      q = ((sum < 0) ? -sum : sum) + 1;
      q = q / 3;
      if (sum < 0) q = -q;
      res.ctr[i] = q[31:0];
      ea[i] = v[3+i] - v[i];
      eb[i] = v[6+i] - v[i];
      if (ea[i] != 0) a_nz = 1'b1;
      if (eb[i] != 0) b_nz = 1'b1;
    end
    cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
    cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
    cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
    ssq = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mg[i] = 256'(neg[i] ? -cr[i] : cr[i]);
      ssq = ssq + mg[i] * mg[i];
    end
    res.ok = a_nz && b_nz && (ssq != 0);
    res.area = '0;
    for (int i = 0; i < 3; i++) res.nrm[i] = '0;
    if (res.ok) begin
      // half the cross magnitude, rounded, saturating
      t = (root_floor(ssq >> (2 * FRAC_BITS)) + 1) >> 1;
      res.area = (|t[255:64]) ? '1 : t[63:0];
      for (int i = 0; i < 3; i++) begin
        t = ((mg[i] * mg[i]) << (2 * NORM_FRAC + 2)) / ssq;
        t = (root_floor(t) + 1) >> 1;
        if (neg[i]) t = -t;
        res.nrm[i] = t[31:0];
      end
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch beat %0d %s: got %h expected %h", checked, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    waiting = 0;
    checked = 0;
    flat_seen = 0;
  end

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    tri_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) result_q.insert(result_q.size(), triangle_props(s_tdata));
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          report("output beat with no triangle pending", 64'd0, 64'd0);
        end else begin
          want = result_q.pop_front();
          if (m_tuser[0] !== want.ok) report("tri_valid", 64'(m_tuser[0]), 64'(want.ok));
          if (m_tdata[63:0] !== want.area) report("area", m_tdata[63:0], want.area);
          for (int i = 0; i < 3; i++) begin
            if (m_tdata[64 + 32*i +: 32] !== want.nrm[i])
              report($sformatf("normal[%0d]", i), 64'(m_tdata[64 + 32*i +: 32]),
                     64'(want.nrm[i]));
            if (m_tdata[160 + 32*i +: 32] !== want.ctr[i])
              report($sformatf("center[%0d]", i), 64'(m_tdata[160 + 32*i +: 32]),
                     64'(want.ctr[i]));
          end
          if (!want.ok) flat_seen++;
          checked++;
        end
      end
      waiting <= result_q.size();
    end
  end
endmodule

@@ tb/triangle_area_normal_centroid_test.sv @@
// ----------------------------------------------------------------------------
// triangle_area_normal_centroid_test
// Drives directed and random triangles with random gaps and output stalls,
// including one long output hold-off; a checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_area_normal_centroid_test;
  import tanc_pkg::*;

  localparam int RANDOM_TRIS = 1680;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  logic                 clk, rst;
  logic                 s_tvalid, s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid, m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic [0:0]           m_tuser;
  int                   fails, waiting, checked, flat_seen;
  int                   sent, rx_cycle;
  logic [31:0]          vtx [9];

  triangle_area_normal_centroid dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  triangle_area_normal_centroid_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fails(fails), .waiting(waiting), .checked(checked), .flat_seen(flat_seen)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // offer one triangle, with a random gap unless in the quiet stretch
  task automatic send_triangle();
    logic [IN_W-1:0] d;
    for (int i = 0; i < 9; i++) d[i*COORD_W +: COORD_W] = vtx[i];
    if (!(sent >= 600 && sent < 900) && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic set_tri(input logic [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    vtx[0] = a0; vtx[1] = a1; vtx[2] = a2;
    vtx[3] = b0; vtx[4] = b1; vtx[5] = b2;
    vtx[6] = c0; vtx[7] = c1; vtx[8] = c2;
    send_triangle();
  endtask

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      default: return 32'd1;
    endcase
  endfunction

  // receiver: random stalls, a quiet stretch and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= 1400 && rx_cycle < 1800) m_tready <= 1'b0;
      else if (rx_cycle >= 900 && rx_cycle < 1300) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 99) >= 22);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d beats checked", checked);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] base, k;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed triangles
    set_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    set_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    set_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    set_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0);
    set_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0);
    set_tri(0, 0, 0, 0, 0, ONE, ONE, 0, 0);
    set_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE);
    set_tri(5, 6, 7, 5, 6, 7, ONE, 3, 9);
    set_tri(5, 6, 7, ONE, 3, 9, 5, 6, 7);
    set_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
    set_tri(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0);
    set_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX);
    set_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
    set_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX);
    set_tri(1, 0, 0, 0, 0, 0, 0, 0, 0);
    set_tri(-1, -1, 2, 0, 0, 0, 0, -1, 0);
    set_tri(1, 2, -2, 0, 0, 0, 1, 0, 0);
    set_tri(1, 0, 0, 0, 1, 0, 0, 0, 1);
    set_tri(-ONE, 3*ONE, 7, 2*ONE, -5*ONE, 11, -9*ONE, ONE, -4*ONE);
    set_tri(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX);

    // random triangles
    repeat (RANDOM_TRIS) begin
      case ($urandom_range(0, 9)) inside
        [0:3]: for (int i = 0; i < 9; i++) vtx[i] = $urandom;
        [4:5]: begin
          base = $urandom;
          for (int i = 0; i < 9; i++)
            vtx[i] = base + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end
        6: begin
          for (int i = 0; i < 9; i++) vtx[i] = $urandom;
          for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 1)) vtx[3+i] = vtx[i];
            else vtx[6+i] = vtx[i];
        end
        7: begin
          for (int i = 0; i < 6; i++) vtx[i] = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
          k = $urandom_range(0, 6) - 3;
          for (int i = 0; i < 3; i++) vtx[6+i] = vtx[i] + k * (vtx[3+i] - vtx[i]);
        end
        8: for (int i = 0; i < 9; i++) vtx[i] = edge_value();
        default: for (int i = 0; i < 9; i++) vtx[i] = $urandom_range(0, 6) - 3;
      endcase
      send_triangle();
    end
    s_tvalid <= 1'b0;

    while (waiting != 0 || checked < sent) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("%0d triangles sent, %0d results checked, %0d of them degenerate",
             sent, checked, flat_seen);
    $display("covered extreme coordinates, flat and collinear cases and a long output stall");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fails);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/tanc_pkg.sv
src/tanc_front.sv
src/tanc_div_cell.sv
src/tanc_sqrt_cell.sv
src/triangle_area_normal_centroid.sv
tb/triangle_area_normal_centroid_checker.sv
tb/triangle_area_normal_centroid_test.sv
